// File: rtl/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

    // upper bound on timers fired by a single tick
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_CREATE = 1'b1;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_CREATED = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] period;
        logic [7:0]  ident;
        logic        rep;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       tick_inc;
        logic       rd_head;
        logic       rd_ins;
        logic       load_create;
        logic       take;
        logic       ins_shift;
        logic       ins_place;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_pend;
        logic       emit_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic full;
        logic fire;
        logic pos_zero;
        logic shift_ok;
        logic pend_vld;
        logic head_rep;
    } t_sts;

endpackage

// File: rtl/stq_datapath.sv
`timescale 1ns / 1ps

module stq_datapath
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_delay_ticks,
    input  logic        i_periodic,
    input  logic        i_out_stall,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_fired_id,
    output logic [31:0] o_now,
    output logic        o_last
);

    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int DEPTH = 1 << IDX_W;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    // table is a circular buffer in deadline order, logical slot 0 at r_head
    t_entry mem [DEPTH];

    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_pos;
    logic [RES_W-1:0] r_nfire;
    logic             r_pend_vld;
    logic [7:0]       r_pend_id;
    t_entry           r_ins;
    t_entry           r_rd;
    logic [7:0]       r_in_id;
    logic [31:0]      r_in_delay;
    logic             r_in_per;
    logic             r_out_vld;
    logic [1:0]       r_out_kind;
    logic [7:0]       r_out_id;
    logic [31:0]      r_out_now;
    logic             r_out_last;

    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             rd_en;
    t_entry           wr_data;
    logic [31:0]      cre_delay;

    assign wr_addr   = r_head + r_pos[IDX_W-1:0];
    assign rd_addr   = i_cmd.rd_head ? r_head : (wr_addr - IDX_W'(1));
    assign wr_en     = i_cmd.ins_shift | i_cmd.ins_place;
    assign rd_en     = i_cmd.rd_head | i_cmd.rd_ins;
    assign wr_data   = i_cmd.ins_shift ? r_rd : r_ins;
    assign cre_delay = (r_in_delay == 32'd0) ? 32'd1 : r_in_delay;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_id    <= i_timer_id;
            r_in_delay <= i_delay_ticks;
            r_in_per   <= i_periodic;
        end
        if (i_cmd.load_create) begin
            r_ins.deadline <= r_now + cre_delay;
            r_ins.period   <= cre_delay;
            r_ins.ident    <= r_in_id;
            r_ins.rep      <= r_in_per;
        end else if (i_cmd.take) begin
            // re-arm from the old deadline
            r_ins.deadline <= r_rd.deadline + r_rd.period;
            r_ins.period   <= r_rd.period;
            r_ins.ident    <= r_rd.ident;
            r_ins.rep      <= r_rd.rep;
        end
        if (i_cmd.take) begin
            r_pend_id <= r_rd.ident;
        end
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.emit_kind;
            r_out_id   <= i_cmd.emit_pend ? r_pend_id : r_in_id;
            r_out_now  <= r_now;
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_count    <= '0;
            r_head     <= '0;
            r_pos      <= '0;
            r_nfire    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.tick_inc) begin
                r_now   <= r_now + 32'd1;
                r_nfire <= '0;
            end
            if (i_cmd.load_create) begin
                r_pos <= r_count;
            end
            if (i_cmd.take) begin
                r_nfire <= r_nfire + RES_W'(1);
                r_head  <= r_head + IDX_W'(1);
                r_count <= r_count - CNT_W'(1);
                r_pos   <= r_count - CNT_W'(1);
            end
            if (i_cmd.ins_shift) begin
                r_pos <= r_pos - CNT_W'(1);
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.take) begin
                r_pend_vld <= 1'b1;
            end else if (i_cmd.emit && i_cmd.emit_pend) begin
                r_pend_vld <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.out_free = !r_out_vld || !i_out_stall;
        o_sts.full     = (r_count == CNT_W'(MAX_TIMERS));
        o_sts.fire     = (r_count != '0) && (r_nfire < RES_W'(MAX_RESULTS))
                         && (r_rd.deadline <= r_now);
        o_sts.pos_zero = (r_pos == '0);
        o_sts.shift_ok = (r_rd.deadline >= r_ins.deadline);
        o_sts.pend_vld = r_pend_vld;
        o_sts.head_rep = r_rd.rep;
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out_kind;
    assign o_fired_id  = r_out_id;
    assign o_now       = r_out_now;
    assign o_last      = r_out_last;

endmodule

// File: rtl/stq_ctrl.sv
`timescale 1ns / 1ps

module stq_ctrl
    import stq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_mode,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CRE       = 8'b0000_0010,
        S_TICK_RD   = 8'b0000_0100,
        S_TICK_CHK  = 8'b0000_1000,
        S_INS_RD    = 8'b0001_0000,
        S_INS_CHK   = 8'b0010_0000,
        S_EMIT_OK   = 8'b0100_0000,
        S_EMIT_FULL = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state ins_done;
    logic   r_is_tick;
    logic   n_is_tick;

    assign ins_done = r_is_tick ? S_TICK_RD : S_EMIT_OK;

    always_comb begin
        n_state   = r_state;
        n_is_tick = r_is_tick;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_is_tick     = (i_mode == MODE_TICK);
                    if (i_mode == MODE_TICK) begin
                        o_cmd.tick_inc = 1'b1;
                        n_state        = S_TICK_RD;
                    end else begin
                        n_state = S_CRE;
                    end
                end
            end
            S_CRE: begin
                if (i_sts.full) begin
                    n_state = S_EMIT_FULL;
                end else begin
                    o_cmd.load_create = 1'b1;
                    n_state           = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (i_sts.pos_zero) begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = ins_done;
                end else begin
                    o_cmd.rd_ins = 1'b1;
                    n_state      = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                // move the neighbour up while it is not earlier than the new deadline
                if (i_sts.shift_ok) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = ins_done;
                end
            end
            S_TICK_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_TICK_CHK;
            end
            S_TICK_CHK: begin
                // held fire result goes out once we know whether another follows
                if (!i_sts.pend_vld || i_sts.out_free) begin
                    if (i_sts.pend_vld) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_FIRED;
                        o_cmd.emit_pend = 1'b1;
                        o_cmd.emit_last = !i_sts.fire;
                    end
                    if (i_sts.fire) begin
                        o_cmd.take = 1'b1;
                        // periodic fire re-inserts before checking the new head
                        n_state    = i_sts.head_rep ? S_INS_RD : S_TICK_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_CREATED;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_FULL;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_tick <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_tick <= n_is_tick;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: rtl/sorted_timer_queue.sv
`timescale 1ns / 1ps

// Deadline-ordered timer table of up to MAX_TIMERS entries held in one
// single-port-read memory. A create item answers with one transfer once the
// entries with a deadline at or after the new one have each been moved up one
// slot through the memory read port, each move being a read state and a check
// state; a further read and check are spent when an earlier entry stays below
// the new slot, and a create rejected on a full table answers without moving
// anything. A tick item advances time and fires due entries in deadline order,
// at most 16 per tick, reading and checking the head for each; a fired periodic
// entry is re-inserted the same way before the next head check. A tick that
// fires nothing produces no transfer. A stall on the result side holds the
// block in its emitting state. Only one item is in work at a time; results wait
// in an output register so a new item can be taken while the last transfer is
// still stalled.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_delay_ticks,
    input  logic        i_periodic,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_fired_id,
    output logic [31:0] o_now,
    output logic        o_last
);

    t_cmd cmd;
    t_sts sts;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    stq_datapath #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timer_id    (i_timer_id),
        .i_delay_ticks (i_delay_ticks),
        .i_periodic    (i_periodic),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_fired_id    (o_fired_id),
        .o_now         (o_now),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall
    ) else $error("accepted item did not make the block busy");

    a_emit_when_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free
    ) else $error("result loaded over an untaken transfer");

    a_no_double_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ins_shift && cmd.ins_place)
    ) else $error("shift and place in the same cycle");

    a_create_single: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit && cmd.emit_kind != KIND_FIRED |=> o_out_valid && o_last
    ) else $error("create result not marked last");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import stq_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int IDLE_PCT       = 12;
    localparam int RANDOM_ITEMS   = 440;
    localparam int TAIL_CYCLES    = 1000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FAR_AHEAD      = 1000;

    typedef struct packed {
        logic        mode;
        logic [7:0]  id;
        logic [31:0] dly;
        logic        rep;
    } t_timer_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [31:0] now;
        logic        last;
    } t_timer_evt;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    logic       calm      = 1'b0;
    t_timer_req cur_req   = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_fired_id;
    logic [31:0] o_now;
    logic        o_last;

    t_timer_req req_q[$];
    t_timer_evt due_q[$];

    // shadow of the timer table
    logic [31:0] now_ticks;
    logic [31:0] tbl_dl  [TABLE_DEPTH];
    logic [31:0] tbl_per [TABLE_DEPTH];
    logic [7:0]  tbl_id  [TABLE_DEPTH];
    logic        tbl_rep [TABLE_DEPTH];
    int          tbl_cnt;

    int errors  = 0;
    int n_creat = 0;
    int n_full  = 0;
    int n_tick  = 0;
    int n_quiet = 0;
    int n_fired = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    sorted_timer_queue #(
        .MAX_TIMERS(TABLE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (cur_req.mode),
        .i_timer_id   (cur_req.id),
        .i_delay_ticks(cur_req.dly),
        .i_periodic   (cur_req.rep),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_kind       (o_kind),
        .o_fired_id   (o_fired_id),
        .o_now        (o_now),
        .o_last       (o_last)
    );

    // new entry goes ahead of every entry with an equal or later deadline
    function automatic void shadow_insert(input logic [31:0] dl, input logic [31:0] per,
                                          input logic [7:0] id, input logic rep);
        int pos;
        pos = tbl_cnt;
        for (int i = tbl_cnt - 1; i >= 0; i--)
            if (dl <= tbl_dl[i]) pos = i;
        for (int i = tbl_cnt; i > pos; i--) begin
            tbl_dl[i]  = tbl_dl[i - 1];
            tbl_per[i] = tbl_per[i - 1];
            tbl_id[i]  = tbl_id[i - 1];
            tbl_rep[i] = tbl_rep[i - 1];
        end
        tbl_dl[pos]  = dl;
        tbl_per[pos] = per;
        tbl_id[pos]  = id;
        tbl_rep[pos] = rep;
        tbl_cnt++;
    endfunction

    function automatic void apply_timer_req(input t_timer_req r);
        logic [31:0] d;
        logic [31:0] dl;
        logic [31:0] per;
        logic [7:0]  fid;
        logic        frep;
        logic [7:0]  fired [MAX_RESULTS];
        int          n;
        n = 0;
        if (r.mode == MODE_CREATE) begin
            d = (r.dly == 32'd0) ? 32'd1 : r.dly;
            n_creat++;
            if (tbl_cnt >= TABLE_DEPTH) begin
                due_q.push_back('{KIND_FULL, r.id, now_ticks, 1'b1});
                n_full++;
            end else begin
                shadow_insert(now_ticks + d, d, r.id, r.rep);
                due_q.push_back('{KIND_CREATED, r.id, now_ticks, 1'b1});
            end
        end else begin
            now_ticks = now_ticks + 32'd1;
            n_tick++;
            // bounded so a wrapped periodic deadline cannot fire forever
            while (tbl_cnt > 0 && n < MAX_RESULTS && tbl_dl[0] <= now_ticks) begin
                dl   = tbl_dl[0];
                per  = tbl_per[0];
                fid  = tbl_id[0];
                frep = tbl_rep[0];
                for (int i = 1; i < tbl_cnt; i++) begin
                    tbl_dl[i - 1]  = tbl_dl[i];
                    tbl_per[i - 1] = tbl_per[i];
                    tbl_id[i - 1]  = tbl_id[i];
                    tbl_rep[i - 1] = tbl_rep[i];
                end
                tbl_cnt--;
                fired[n] = fid;
                n++;
                if (frep) shadow_insert(dl + per, per, fid, frep);
            end
            if (n == 0) n_quiet++;
            for (int i = 0; i < n; i++)
                due_q.push_back('{KIND_FIRED, fired[i], now_ticks, (i == n - 1)});
            n_fired += n;
        end
    endfunction

    // entries that will hold a slot for the rest of the run
    function automatic int lasting_timers();
        int c;
        c = 0;
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_rep[i] || tbl_dl[i] > now_ticks + FAR_AHEAD) c++;
        return c;
    endfunction

    function automatic int periodic_timers();
        int c;
        c = 0;
        for (int i = 0; i < tbl_cnt; i++)
            if (tbl_rep[i]) c++;
        return c;
    endfunction

    function automatic void queue_req(input logic mode, input logic [7:0] id,
                                      input logic [31:0] dly, input logic rep);
        req_q.push_back('{mode, id, dly, rep});
    endfunction

    function automatic void queue_tick();
        queue_req(MODE_TICK, 8'($urandom_range(0, 255)), $urandom(),
                  1'($urandom_range(0, 1)));
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) apply_timer_req(cur_req);
            if (!in_valid || !o_in_stall) begin
                if (req_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_req  <= req_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : result_check
        t_timer_evt got;
        t_timer_evt want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = '{o_kind, o_fired_id, o_now, o_last};
            if (due_q.size() == 0) begin
                $display("%0t: unexpected transfer kind %0d id %0d now %0d last %0d",
                         $time, got.kind, got.id, got.now, got.last);
                errors++;
            end else begin
                want = due_q.pop_front();
                if (got.kind !== want.kind || got.id !== want.id ||
                    got.now !== want.now || got.last !== want.last) begin
                    $display("%0t: expected kind %0d id %0d now %0d last %0d, got kind %0d id %0d now %0d last %0d",
                             $time, want.kind, want.id, want.now, want.last,
                             got.kind, got.id, got.now, got.last);
                    errors++;
                end
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("sorted_timer_queue: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          r;
        int          create_pct;
        logic [31:0] d;
        logic        rep;
        now_ticks = 32'd0;
        tbl_cnt   = 0;

        // zero delay, then an equal deadline that must land ahead of it
        queue_req(MODE_CREATE, 8'h00, 32'd0, 1'b0);
        queue_req(MODE_CREATE, 8'hFF, 32'd1, 1'b0);
        queue_tick();
        queue_tick();
        // wrapped deadlines; the periodic one re-fires until the per-tick bound
        queue_req(MODE_CREATE, 8'h5A, 32'hFFFF_FFFF, 1'b0);
        queue_req(MODE_CREATE, 8'hA5, 32'hFFFF_FFFF, 1'b1);
        for (int j = 0; j < 14; j++)
            queue_req(MODE_CREATE, 8'(8'h10 + j), 32'd1, 1'b0);
        queue_req(MODE_CREATE, 8'hC3, $urandom(), 1'b1);
        queue_tick();
        queue_tick();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            while (req_q.size() >= 3) @(negedge i_clk);
            calm = (k >= 200 && k < 280);
            create_pct = ((k / 40) % 2 == 0) ? 70 : 30;
            if ($urandom_range(0, 99) < create_pct) begin
                r   = $urandom_range(0, 99);
                rep = 1'b0;
                if (r < 6 && lasting_timers() < 7) begin
                    d   = $urandom();
                    rep = 1'($urandom_range(0, 1));
                end else if (r < 10) begin
                    d = 32'd0;
                end else if (r < 15) begin
                    d = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
                end else if (r < 27 && periodic_timers() < 4) begin
                    d   = $urandom_range(8, 60);
                    rep = 1'b1;
                end else begin
                    d = $urandom_range(1, 40);
                end
                queue_req(MODE_CREATE, 8'($urandom_range(0, 255)), d, rep);
            end else begin
                queue_tick();
            end
        end
        calm = 1'b0;

        while (req_q.size() > 0 || in_valid || due_q.size() > 0) @(negedge i_clk);
        // a trailing tick may still be scanning with nothing to report
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d creates (%0d refused on a full table) and %0d ticks (%0d quiet)",
                 n_creat, n_full, n_tick, n_quiet);
        $display("%0d expiries checked, %0d errors", n_fired, errors);
        if (errors == 0)
            $display("sorted_timer_queue: match");
        else
            $display("sorted_timer_queue: mismatch");
        $finish;
    end

endmodule
